// ===== design/eatrm_pkg.sv =====
// shared constants, types and functions for the euler angle rotation matrix core
`default_nettype none
package eatrm_pkg;
	localparam int WORK_FRAC = 30;
	localparam int CORDIC_STEPS = 30;
	localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
	localparam int WW = 34;

	typedef logic signed [WW-1:0] work_t;

	typedef struct packed {
		work_t x;
		work_t y;
		work_t z;
		logic [1:0] quad;
	} cordic_t;

	function automatic work_t atan_tab(input int i);
		case (i)
			0: atan_tab = 34'sd536870912;
			1: atan_tab = 34'sd316933406;
			2: atan_tab = 34'sd167458907;
			3: atan_tab = 34'sd85004756;
			4: atan_tab = 34'sd42667331;
			5: atan_tab = 34'sd21354465;
			6: atan_tab = 34'sd10679838;
			7: atan_tab = 34'sd5340245;
			8: atan_tab = 34'sd2670163;
			9: atan_tab = 34'sd1335087;
			10: atan_tab = 34'sd667544;
			11: atan_tab = 34'sd333772;
			12: atan_tab = 34'sd166886;
			13: atan_tab = 34'sd83443;
			14: atan_tab = 34'sd41722;
			15: atan_tab = 34'sd20861;
			16: atan_tab = 34'sd10430;
			17: atan_tab = 34'sd5215;
			18: atan_tab = 34'sd2608;
			19: atan_tab = 34'sd1304;
			20: atan_tab = 34'sd652;
			21: atan_tab = 34'sd326;
			22: atan_tab = 34'sd163;
			23: atan_tab = 34'sd81;
			24: atan_tab = 34'sd41;
			25: atan_tab = 34'sd20;
			26: atan_tab = 34'sd10;
			27: atan_tab = 34'sd5;
			28: atan_tab = 34'sd3;
			29: atan_tab = 34'sd1;
			default: atan_tab = '0;
		endcase
	endfunction

	// q4.30 product rounded back to q4.30
	function automatic work_t qmul(input work_t a, input work_t b);
		logic signed [2*WW-1:0] p;
		begin
			p = a * b;
			p = p + (68'sd1 <<< (WORK_FRAC - 1));
			qmul = work_t'(p >>> WORK_FRAC);
		end
	endfunction
endpackage
`default_nettype wire

// ===== design/eatrm_sincos.sv =====
// pipelined quadrant fold and cordic giving sine and cosine of one angle
`default_nettype none
module eatrm_sincos import eatrm_pkg::*; #(
	parameter int ANGLE_BITS = 16
) (
	input wire logic clk,
	input wire logic en,
	input wire logic [ANGLE_BITS-1:0] angle,
	output work_t cos_o,
	output work_t sin_o
);
	cordic_t stg_s1 [CORDIC_STEPS+1];
	work_t cos_s2, sin_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			logic [31:0] a, ru;
			logic [1:0] q;
			a = {angle, {(32-ANGLE_BITS){1'b0}}};
			q = 2'((a + 32'h20000000) >> 30);
			ru = a - {q, 30'd0};
			stg_s1[0].x <= CORDIC_X0;
			stg_s1[0].y <= '0;
			stg_s1[0].z <= work_t'(signed'(ru));
			stg_s1[0].quad <= q;
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				stg_s1[i+1].quad <= stg_s1[i].quad;
				if (!stg_s1[i].z[WW-1]) begin
					stg_s1[i+1].x <= stg_s1[i].x - (stg_s1[i].y >>> i);
					stg_s1[i+1].y <= stg_s1[i].y + (stg_s1[i].x >>> i);
					stg_s1[i+1].z <= stg_s1[i].z - atan_tab(i);
				end else begin
					stg_s1[i+1].x <= stg_s1[i].x + (stg_s1[i].y >>> i);
					stg_s1[i+1].y <= stg_s1[i].y - (stg_s1[i].x >>> i);
					stg_s1[i+1].z <= stg_s1[i].z + atan_tab(i);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			case (stg_s1[CORDIC_STEPS].quad)
				2'd0: begin
					cos_s2 <= stg_s1[CORDIC_STEPS].x;
					sin_s2 <= stg_s1[CORDIC_STEPS].y;
				end
				2'd1: begin
					cos_s2 <= -stg_s1[CORDIC_STEPS].y;
					sin_s2 <= stg_s1[CORDIC_STEPS].x;
				end
				2'd2: begin
					cos_s2 <= -stg_s1[CORDIC_STEPS].x;
					sin_s2 <= -stg_s1[CORDIC_STEPS].y;
				end
				default: begin
					cos_s2 <= stg_s1[CORDIC_STEPS].y;
					sin_s2 <= -stg_s1[CORDIC_STEPS].x;
				end
			endcase
		end
	end

	assign cos_o = cos_s2;
	assign sin_o = sin_s2;
endmodule
`default_nettype wire

// ===== design/eatrm_matrix.sv =====
// product formulas, rounding and saturation of the nine entries
`default_nettype none
module eatrm_matrix import eatrm_pkg::*; #(
	parameter int OUT_FRAC_BITS = 14
) (
	input wire logic clk,
	input wire logic en,
	input wire work_t ch, sh, ca, sa, cb, sb,
	output logic [9*(OUT_FRAC_BITS+2)-1:0] mat
);
	localparam int OW = OUT_FRAC_BITS + 2;
	localparam int SH = WORK_FRAC - OUT_FRAC_BITS;

	work_t chsa_s1, shsa_s1, chca_s1, shsb_s1, shcb_s1, cacb_s1, casb_s1, shca_s1;
	work_t chsb_s1, chcb_s1, sa_s1, cb_s1, sb_s1;
	work_t v_s2 [9];

	always_ff @(posedge clk) begin
		if (en) begin
			chsa_s1 <= qmul(ch, sa);
			shsa_s1 <= qmul(sh, sa);
			chca_s1 <= qmul(ch, ca);
			shsb_s1 <= qmul(sh, sb);
			shcb_s1 <= qmul(sh, cb);
			cacb_s1 <= qmul(ca, cb);
			casb_s1 <= qmul(ca, sb);
			shca_s1 <= qmul(sh, ca);
			chsb_s1 <= qmul(ch, sb);
			chcb_s1 <= qmul(ch, cb);
			sa_s1 <= sa;
			cb_s1 <= cb;
			sb_s1 <= sb;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s2[0] <= chca_s1;
			v_s2[1] <= shsb_s1 - qmul(chsa_s1, cb_s1);
			v_s2[2] <= qmul(chsa_s1, sb_s1) + shcb_s1;
			v_s2[3] <= sa_s1;
			v_s2[4] <= cacb_s1;
			v_s2[5] <= -casb_s1;
			v_s2[6] <= -shca_s1;
			v_s2[7] <= qmul(shsa_s1, cb_s1) + chsb_s1;
			v_s2[8] <= chcb_s1 - qmul(shsa_s1, sb_s1);
		end
	end

	for (genvar k = 0; k < 9; k++) begin : g_out
		always_ff @(posedge clk) begin
			if (en) begin
				logic signed [WW:0] r, lim;
				lim = (WW+1)'(1) <<< OUT_FRAC_BITS;
				if (SH == 0) r = (WW+1)'(v_s2[k]);
				else r = ((WW+1)'(v_s2[k]) + ((WW+1)'(1) <<< (SH > 0 ? SH-1 : 0))) >>> SH;
				if (r > lim) r = lim;
				if (r < -lim) r = -lim;
				mat[k*OW +: OW] <= r[OW-1:0];
			end
		end
	end
endmodule
`default_nettype wire

// ===== design/euler_angles_to_rotation_matrix_core.sv =====
// euler angles (heading, attitude, bank) to rotation matrix, top level
// channels: s_axis carries heading, attitude and bank angles in one transaction,
// m_axis returns the nine q2.frac matrix entries m00..m22 in one transaction.
// the path from input to output register is: one fold stage,
// 30 cordic stages, one quadrant restore stage, three product and output stages.
// throughput is one transaction per cycle while m_axis does not stall; every stage is a pipeline register.
// the whole pipeline advances when the output register is empty or being taken,
// so a stall at m_axis holds every stage and loses nothing.
// s_axis_tready follows that same enable.
// reset clears the valid bits only; the data path needs no reset.
// the block keeps no state between transactions.
`default_nettype none
module euler_angles_to_rotation_matrix_core import eatrm_pkg::*; #(
	parameter int ANGLE_BITS = 16,
	parameter int OUT_FRAC_BITS = 14
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	// heading_angle, attitude_angle, bank_angle
	input wire logic [((3*ANGLE_BITS+7)/8)*8-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	// m00, m01, m02, m10, m11, m12, m20, m21, m22
	output logic [((9*(OUT_FRAC_BITS+2)+7)/8)*8-1:0] m_axis_tdata
);
	localparam int LAT = CORDIC_STEPS + 5;
	localparam int OW = OUT_FRAC_BITS + 2;
	localparam int DW = ((9*OW+7)/8)*8;

	logic [LAT-1:0] vld_s1;
	logic en;
	work_t ch, sh, ca, sa, cb, sb;
	logic [9*OW-1:0] mat;

	assign en = !vld_s1[LAT-1] || m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= '0;
		end else if (en) begin
			vld_s1 <= {vld_s1[LAT-2:0], s_axis_tvalid};
		end
	end

	eatrm_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_h (.clk(clk), .en(en),
		.angle(s_axis_tdata[0 +: ANGLE_BITS]), .cos_o(ch), .sin_o(sh));
	eatrm_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_a (.clk(clk), .en(en),
		.angle(s_axis_tdata[ANGLE_BITS +: ANGLE_BITS]), .cos_o(ca), .sin_o(sa));
	eatrm_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_b (.clk(clk), .en(en),
		.angle(s_axis_tdata[2*ANGLE_BITS +: ANGLE_BITS]), .cos_o(cb), .sin_o(sb));

	eatrm_matrix #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_mat (.clk(clk), .en(en),
		.ch(ch), .sh(sh), .ca(ca), .sa(sa), .cb(cb), .sb(sb), .mat(mat));

	assign m_axis_tvalid = vld_s1[LAT-1];
	assign m_axis_tdata = DW'(mat);
endmodule
`default_nettype wire

// ===== sim/tb_euler_angles_to_rotation_matrix_core.sv =====
// testbench for the euler angle rotation matrix core: directed and random angle triples
`timescale 1ns / 100ps
`default_nettype none
module tb_euler_angles_to_rotation_matrix_core;
	import eatrm_pkg::*;

	localparam int ANGLE_BITS = 16;
	localparam int OUT_FRAC_BITS = 14;
	localparam int OUT_W = OUT_FRAC_BITS + 2;
	localparam int IN_BYTES_W = ((3*ANGLE_BITS+7)/8)*8;
	localparam int OUT_BYTES_W = ((9*OUT_W+7)/8)*8;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 60;

	typedef logic signed [63:0] wide_t;
	typedef logic [8:0][OUT_W-1:0] matrix_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_BYTES_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_BYTES_W-1:0] m_axis_tdata;

	matrix_t matrix_q[$];
	int error_count = 0;
	int idle_cycles = 0;
	bit stall_enable = 1'b1;

	euler_angles_to_rotation_matrix_core #(
		.ANGLE_BITS(ANGLE_BITS),
		.OUT_FRAC_BITS(OUT_FRAC_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #10 clk = ~clk;

	function automatic wide_t floor_shr(input wide_t v, input int s);
		return v >>> s;
	endfunction

	function automatic wide_t round_q30(input wide_t a, input wide_t b);
		return (a * b + (64'sd1 <<< 29)) >>> 30;
	endfunction

	task automatic angle_sincos(input logic [ANGLE_BITS-1:0] ang, output wide_t c,
			output wide_t s);
		logic [31:0] a;
		logic [1:0] q;
		logic [31:0] ru;
		wide_t x, y, z, dx, dy, t;
		a = {ang, {(32-ANGLE_BITS){1'b0}}};
		q = 2'((a + 32'h2000_0000) >> 30);
		ru = a - ({30'd0, q} << 30);
		z = wide_t'(signed'(ru));
		x = 652032874;
		y = 0;
		for (int i = 0; i < 30; i++) begin
			dx = floor_shr(y, i);
			dy = floor_shr(x, i);
			t = wide_t'(atan_tab(i));
			if (z >= 0) begin
				x -= dx; y += dy; z -= t;
			end else begin
				x += dx; y -= dy; z += t;
			end
		end
		case (q)
			2'd0: begin c = x; s = y; end
			2'd1: begin c = -y; s = x; end
			2'd2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
	endtask

	function automatic logic [OUT_W-1:0] to_entry(input wide_t v);
		wide_t r;
		wide_t lim;
		localparam int SH = 30 - OUT_FRAC_BITS;
		lim = 64'sd1 <<< OUT_FRAC_BITS;
		r = (SH == 0) ? v : ((v + (64'sd1 <<< (SH-1))) >>> SH);
		if (r > lim) r = lim;
		if (r < -lim) r = -lim;
		return r[OUT_W-1:0];
	endfunction

	task automatic predict_matrix(input logic [ANGLE_BITS-1:0] hd, input logic [ANGLE_BITS-1:0] at,
			input logic [ANGLE_BITS-1:0] bk, output matrix_t m);
		wide_t ch, sh, ca, sa, cb, sb;
		angle_sincos(hd, ch, sh);
		angle_sincos(at, ca, sa);
		angle_sincos(bk, cb, sb);
		m[0] = to_entry(round_q30(ch, ca));
		m[1] = to_entry(round_q30(sh, sb) - round_q30(round_q30(ch, sa), cb));
		m[2] = to_entry(round_q30(round_q30(ch, sa), sb) + round_q30(sh, cb));
		m[3] = to_entry(sa);
		m[4] = to_entry(round_q30(ca, cb));
		m[5] = to_entry(-round_q30(ca, sb));
		m[6] = to_entry(-round_q30(sh, ca));
		m[7] = to_entry(round_q30(round_q30(sh, sa), cb) + round_q30(ch, sb));
		m[8] = to_entry(round_q30(ch, cb) - round_q30(round_q30(sh, sa), sb));
	endtask

	function automatic int gap_len();
		if (!stall_enable) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
		if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
		return 0;
	endfunction

	task automatic send_angles(input logic [ANGLE_BITS-1:0] hd, input logic [ANGLE_BITS-1:0] at,
			input logic [ANGLE_BITS-1:0] bk);
		matrix_t m;
		int gap;
		predict_matrix(hd, at, bk, m);
		gap = gap_len();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= IN_BYTES_W'({bk, at, hd});
		matrix_q.push_back(m);
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic end_burst();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			matrix_t exp_m;
			matrix_t act_m;
			act_m = m_axis_tdata[9*OUT_W-1:0];
			if (matrix_q.size() == 0) begin
				$error("result transaction with nothing expected: %h", act_m);
				error_count++;
			end else begin
				exp_m = matrix_q.pop_front();
				for (int k = 0; k < 9; k++)
					if (exp_m[k] !== act_m[k]) begin
						$error("m%0d%0d: expected %0d, actual %0d", k/3, k%3,
							$signed(exp_m[k]), $signed(act_m[k]));
						error_count++;
					end
			end
		end
	end

	always @(posedge clk) begin
		if (!stall_enable) m_axis_tready <= 1'b1;
		else if ($urandom_range(0, 49) == 0) m_axis_tready <= 1'b0;
		else if ($urandom_range(0, 3) == 0) m_axis_tready <= ~m_axis_tready;
		else m_axis_tready <= 1'b1;
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else if (matrix_q.size() != 0 || s_axis_tvalid)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_euler_angles_to_rotation_matrix_core: done, errors");
			$finish;
		end
	end

	task automatic wait_drained();
		while (matrix_q.size() != 0) @(posedge clk);
	endtask

	task automatic test_extremes();
		logic [15:0] v[8];
		v = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h4000, 16'hc000, 16'h2000, 16'h0001};
		for (int i = 0; i < 8; i++)
			send_angles(v[i], v[(i+3)%8], v[(i+5)%8]);
		send_angles(16'h2000, 16'h2000, 16'h2000);
		send_angles(16'h1fff, 16'he000, 16'hdfff);
		send_angles(16'h4000, 16'h4000, 16'h4000);
		send_angles(16'h8000, 16'h8000, 16'h8000);
		send_angles(16'h7fff, 16'h7fff, 16'h7fff);
		send_angles(16'h6000, 16'ha000, 16'h5fff);
		end_burst();
	endtask

	task automatic test_backlog_pause();
		for (int i = 0; i < 20; i++)
			send_angles(16'($urandom), 16'($urandom), 16'($urandom));
		end_burst();
		wait_drained();
	endtask

	task automatic test_random(input int n);
		logic [15:0] a[3];
		for (int i = 0; i < n; i++) begin
			for (int j = 0; j < 3; j++)
				case ($urandom_range(0, 5))
					0: a[j] = 16'($urandom_range(0, 3)) << 14;
					1: a[j] = (16'($urandom_range(0, 7)) << 13) + 16'($urandom_range(0, 2)) - 16'd1;
					default: a[j] = 16'($urandom);
				endcase
			send_angles(a[0], a[1], a[2]);
		end
		end_burst();
	endtask

	task automatic test_full_rate(input int n);
		stall_enable = 1'b0;
		for (int i = 0; i < n; i++)
			send_angles(16'($urandom), 16'($urandom), 16'($urandom));
		end_burst();
		wait_drained();
		stall_enable = 1'b1;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_backlog_pause();
		test_random(330);
		test_full_rate(80);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("tb_euler_angles_to_rotation_matrix_core: done, clean");
		else
			$display("tb_euler_angles_to_rotation_matrix_core: done, errors");
		$finish;
	end
endmodule
`default_nettype wire
